// ----- rtl/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// Pulse train capture package
// Shared constants, codes and structs of the pulse train capture unit.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int BUFFER_DEPTH = 128;
  localparam int BUFFER_COUNT = 2;
  localparam int TICK_BITS    = 15;

  // Entry index within one buffer, entry count, and store address widths.
  localparam int IDX_W     = $clog2(BUFFER_DEPTH);
  localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
  localparam int MEM_AW    = IDX_W + 1;
  localparam int MEM_DEPTH = BUFFER_COUNT << IDX_W;

  // Register field widths.
  localparam int PULSE_W = 15;
  localparam int EDGES_W = 8;
  localparam int DATA_W  = 15;
  localparam int LEN_W   = 8;
  localparam int RIDX_W  = 7;

  // Width in which tick counts, timeouts and pulse limits are compared.
  localparam int TMO_W = (TICK_BITS > PULSE_W) ? TICK_BITS : PULSE_W;

  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  localparam logic [PULSE_W-1:0] MIN_PULSE_RST    = 15'd25;
  localparam logic [EDGES_W-1:0] MIN_EDGES_RST    = 8'd40;
  localparam logic [PULSE_W-1:0] IDLE_TIMEOUT_RST = 15'h7FFF;

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MIN_PULSE    = 2'd0;
  localparam reg_idx_t REG_MIN_EDGES    = 2'd1;
  localparam reg_idx_t REG_IDLE_TIMEOUT = 2'd2;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_TICK    = 2'd0;
  localparam mode_t MODE_READ    = 2'd1;
  localparam mode_t MODE_RELEASE = 2'd2;

  typedef struct packed {
    logic [PULSE_W-1:0] min_pulse;
    logic [EDGES_W-1:0] min_edges;
    logic [PULSE_W-1:0] idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic             acquiring;
    logic             train_ready;
    logic [LEN_W-1:0] ready_length;
    logic             train_accepted;
    logic             train_discarded;
    logic             rd_hit;
  } stat_t;

endpackage

// ----- rtl/ptc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module ptc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ptc_cfg.sv -----
// ----------------------------------------------------------------------------
// Pulse train capture configuration registers
// APB-style register file for pulse limit, edge count and idle timeout.
// ----------------------------------------------------------------------------
module ptc_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [ptc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ptc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ptc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output ptc_pkg::cfg_t             cfg
);

  import ptc_pkg::*;

  logic [PULSE_W-1:0] min_pulse_r;
  logic [EDGES_W-1:0] min_edges_r;
  logic [PULSE_W-1:0] idle_timeout_r;
  reg_idx_t           idx;
  logic               wr_en;

  assign idx        = cfg_paddr[CFG_AW-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r    <= MIN_PULSE_RST;
      min_edges_r    <= MIN_EDGES_RST;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_PULSE:    min_pulse_r    <= cfg_pwdata[PULSE_W-1:0];
        REG_MIN_EDGES:    min_edges_r    <= cfg_pwdata[EDGES_W-1:0];
        REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_pwdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_PULSE:    cfg_prdata = CFG_DW'(min_pulse_r);
      REG_MIN_EDGES:    cfg_prdata = CFG_DW'(min_edges_r);
      REG_IDLE_TIMEOUT: cfg_prdata = CFG_DW'(idle_timeout_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg.min_pulse    = min_pulse_r;
  assign cfg.min_edges    = min_edges_r;
  assign cfg.idle_timeout = idle_timeout_r;

endmodule

// ----- rtl/ptc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Pulse train capture control
// Edge detection, interval timing, buffer bookkeeping and store access.
// ----------------------------------------------------------------------------
module ptc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  input  ptc_pkg::mode_t              mode,
  input  logic                        line_level,
  input  logic [ptc_pkg::RIDX_W-1:0]  read_index,
  input  ptc_pkg::cfg_t               cfg,
  output logic                        mem_we,
  output logic [ptc_pkg::MEM_AW-1:0]  mem_waddr,
  output logic [ptc_pkg::TICK_BITS-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [ptc_pkg::MEM_AW-1:0]  mem_raddr,
  output ptc_pkg::stat_t              stat
);

  import ptc_pkg::*;

  logic [CNT_W-1:0]     cnt_r   [BUFFER_COUNT];
  logic [CNT_W-1:0]     cnt_nxt [BUFFER_COUNT];
  logic                 write_sel_r, write_sel_nxt;
  logic                 ready_sel_r, ready_sel_nxt;
  logic                 ready_valid_r, ready_valid_nxt;
  logic [TICK_BITS-1:0] tick_r, tick_nxt;
  logic [TMO_W-1:0]     timeout_r, timeout_nxt;
  logic                 expect_rise_r, expect_rise_nxt;
  logic                 last_level_r, last_level_nxt;
  logic                 acquire_r, acquire_nxt;
  logic [TICK_BITS-1:0] first_r, first_nxt;

  logic                 ws;
  logic                 rs;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     n1;
  logic [TICK_BITS-1:0] tick_inc;
  logic [TICK_BITS:0]   pair_sum;
  logic                 edge_hit;
  logic                 accepted;
  logic                 discarded;
  logic                 rd_hit;

  always_comb begin
    cnt_nxt         = cnt_r;
    write_sel_nxt   = write_sel_r;
    ready_sel_nxt   = ready_sel_r;
    ready_valid_nxt = ready_valid_r;
    tick_nxt        = tick_r;
    timeout_nxt     = timeout_r;
    expect_rise_nxt = expect_rise_r;
    last_level_nxt  = last_level_r;
    acquire_nxt     = acquire_r;
    first_nxt       = first_r;
    accepted        = 1'b0;
    discarded       = 1'b0;
    rd_hit          = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;

    ws        = write_sel_r;
    rs        = ready_sel_r;
    n         = cnt_r[ws];
    n1        = n + CNT_W'(1);
    tick_inc  = (tick_r != TICK_MAX) ? tick_r + TICK_BITS'(1) : tick_r;
    pair_sum  = {1'b0, first_r} + {1'b0, tick_inc};
    edge_hit  = expect_rise_r ? (!last_level_r && line_level)
                              : (last_level_r && !line_level);
    mem_waddr = {ws, n[IDX_W-1:0]};
    mem_wdata = tick_inc;
    mem_raddr = {rs, IDX_W'(read_index)};

    if (item_valid) begin
      case (mode)
        MODE_TICK: begin
          last_level_nxt = line_level;
          tick_nxt       = tick_inc;
          if (edge_hit) begin
            tick_nxt = '0;
            if (TMO_W'(tick_inc) < TMO_W'(cfg.min_pulse) ||
                n >= CNT_W'(BUFFER_DEPTH)) begin
              cnt_nxt[ws]     = '0;
              timeout_nxt     = TMO_W'(cfg.idle_timeout);
              expect_rise_nxt = 1'b1;
              acquire_nxt     = 1'b0;
              discarded       = 1'b1;
            end else begin
              mem_we = 1'b1;
              if (n == '0) begin
                first_nxt = tick_inc;
              end
              if (n1 >= CNT_W'(BUFFER_DEPTH)) begin
                cnt_nxt[ws]     = '0;
                timeout_nxt     = TMO_W'(cfg.idle_timeout);
                expect_rise_nxt = 1'b1;
                acquire_nxt     = 1'b0;
                discarded       = 1'b1;
              end else begin
                cnt_nxt[ws]     = n1;
                expect_rise_nxt = !expect_rise_r;
                // The second entry sets the timeout to the mean of the first two.
                if (n1 == CNT_W'(2)) begin
                  timeout_nxt = TMO_W'(pair_sum[TICK_BITS:1]);
                end else begin
                  acquire_nxt = 1'b1;
                end
              end
            end
          end else if (TMO_W'(tick_inc) >= timeout_r) begin
            tick_nxt = '0;
            if (EDGES_W'(n) > cfg.min_edges) begin
              ready_sel_nxt   = ws;
              ready_valid_nxt = 1'b1;
              write_sel_nxt   = !ws;
              cnt_nxt[!ws]    = '0;
              accepted        = 1'b1;
            end else begin
              discarded   = (n != '0);
              cnt_nxt[ws] = '0;
            end
            timeout_nxt     = TMO_W'(cfg.idle_timeout);
            expect_rise_nxt = 1'b1;
            acquire_nxt     = 1'b0;
          end
        end
        MODE_READ: begin
          mem_re = 1'b1;
          rd_hit = ready_valid_r && (LEN_W'(read_index) < LEN_W'(cnt_r[rs]));
        end
        MODE_RELEASE: begin
          if (ready_valid_r) begin
            cnt_nxt[rs]     = '0;
            ready_valid_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        cnt_r[i] <= '0;
      end
      write_sel_r   <= 1'b0;
      ready_sel_r   <= 1'b0;
      ready_valid_r <= 1'b0;
      tick_r        <= '0;
      timeout_r     <= TMO_W'(IDLE_TIMEOUT_RST);
      expect_rise_r <= 1'b1;
      last_level_r  <= 1'b0;
      acquire_r     <= 1'b0;
    end else begin
      cnt_r         <= cnt_nxt;
      write_sel_r   <= write_sel_nxt;
      ready_sel_r   <= ready_sel_nxt;
      ready_valid_r <= ready_valid_nxt;
      tick_r        <= tick_nxt;
      timeout_r     <= timeout_nxt;
      expect_rise_r <= expect_rise_nxt;
      last_level_r  <= last_level_nxt;
      acquire_r     <= acquire_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
  end

  assign stat.acquiring       = acquire_nxt;
  assign stat.train_ready     = ready_valid_nxt;
  assign stat.ready_length    = ready_valid_nxt ? LEN_W'(cnt_nxt[ready_sel_nxt]) : '0;
  assign stat.train_accepted  = accepted;
  assign stat.train_discarded = discarded;
  assign stat.rd_hit          = rd_hit;

  // The ready buffer is never the one being filled.
  a_ready_apart: assert property (@(posedge clk) disable iff (!rst_n)
    ready_valid_r |-> (ready_sel_r != write_sel_r))
    else $error("ready buffer coincides with write buffer");

  // The write buffer is flushed before it can reach full depth.
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[write_sel_r] < CNT_W'(BUFFER_DEPTH))
    else $error("write buffer count reached full depth");

  // A store write never targets the buffer handed to the reader.
  a_write_target: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && ready_valid_r) |-> (mem_waddr[MEM_AW-1] != ready_sel_r))
    else $error("store write into the ready buffer");

  // An accepted train clears the tick counter at the next edge.
  a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accepted |=> (tick_r == '0 && ready_valid_r))
    else $error("train hand-over did not settle");

endmodule

// ----- rtl/pulse_train_capture_unit.sv -----
// ----------------------------------------------------------------------------
// Pulse train capture unit
// Double-buffered capture of infrared pulse trains from timer tick items.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one item per timer tick, buffer read or buffer
//   release; in_tuser holds the item kind. Every accepted item gives exactly
//   one result item on the out_ channel, in order.
//   Intervals live in a 2 x BUFFER_DEPTH entry store with a registered read;
//   all other state sits in flip-flops. A result appears in the cycle after
//   its item is accepted, and one item is taken per cycle when the receiver
//   keeps out_tready high. Read data comes straight from the store's read
//   register, which is loaded alongside the output register.
//   When the receiver stalls, the pending result holds and in_tready falls
//   until it is taken.
//   Reset is synchronous: counts, selects, flags, tick and timeout return to
//   their defaults; first-interval and result registers are not reset. Store
//   contents are not cleared; an entry is only returned when it lies below its
//   buffer's count, so no clearing pass is needed and items are taken right after reset.
//   Configuration is written over the cfg_ APB port while the unit is idle.
// ----------------------------------------------------------------------------
module pulse_train_capture_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [0] line_level, [7:1] read_index
  input  logic [7:0]                 in_tdata,
  // [1:0] mode
  input  logic [1:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [0] acquiring, [1] train_ready, [9:2] ready_length, [24:10] read_data,
  // [25] train_accepted, [26] train_discarded, [31:27] zero
  output logic [31:0]                out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ptc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ptc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ptc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  import ptc_pkg::*;

  cfg_t                 cfg;
  stat_t                stat;
  stat_t                stat_r;
  logic                 out_valid_r;
  logic                 accept;
  logic                 mem_we;
  logic                 mem_re;
  logic [MEM_AW-1:0]    mem_waddr;
  logic [MEM_AW-1:0]    mem_raddr;
  logic [TICK_BITS-1:0] mem_wdata;
  logic [TICK_BITS-1:0] mem_rdata;
  logic [DATA_W-1:0]    read_data;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  ptc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ptc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (accept),
    .mode       (in_tuser),
    .line_level (in_tdata[0]),
    .read_index (in_tdata[7:1]),
    .cfg        (cfg),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .stat       (stat)
  );

  // The store is read only on accepted items, so its read register holds
  // the pending result's data through a stall.
  ptc_ram #(
    .WIDTH (TICK_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat_r <= stat;
    end
  end

  assign read_data  = stat_r.rd_hit ? DATA_W'(mem_rdata) : '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, stat_r.train_discarded, stat_r.train_accepted, read_data,
                       stat_r.ready_length, stat_r.train_ready, stat_r.acquiring};

endmodule
